// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stuffed frame receiver
// Parse phases, event codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MaxPayload = 1024;
  localparam int CountW     = $clog2(MaxPayload + 2);
  localparam int ByteW      = 8;
  localparam int KindW      = 3;
  localparam int LenW       = 11;
  localparam int CfgIdxW    = 3;

  localparam logic [CountW-1:0] CountLimit = CountW'(MaxPayload + 1);

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [2:0] {
    PH_FLAG = 3'd0,
    PH_ADDR = 3'd1,
    PH_CTRL = 3'd2,
    PH_HCHK = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef enum logic [KindW-1:0] {
    EV_BYTE  = 3'd0,
    EV_GOOD  = 3'd1,
    EV_CHECK = 3'd2,
    EV_DUP   = 3'd3,
    EV_ABORT = 3'd4
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FLAG       = 3'd0,
    REG_ESCAPE     = 3'd1,
    REG_STUFF_FLAG = 3'd2,
    REG_ESC_ESC    = 3'd3,
    REG_ADDRESS    = 3'd4,
    REG_CTRL_SEQ0  = 3'd5,
    REG_CTRL_SEQ1  = 3'd6
  } cfg_reg_e;

  localparam byte_t FlagReset    = 8'h7E;
  localparam byte_t EscapeReset  = 8'h7D;
  localparam byte_t EscFlagReset = 8'h5E;
  localparam byte_t EscEscReset  = 8'h5D;
  localparam byte_t AddressReset = 8'h03;
  localparam byte_t CtrlS0Reset  = 8'h00;
  localparam byte_t CtrlS1Reset  = 8'h80;

endpackage

// ===== design/sfr_if.sv =====
// ----------------------------------------------------------------------------
// sfr_rx_if / sfr_ev_if: valid/ready channels of the stuffed frame receiver
// Line byte channel in, event channel out.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
  logic               valid;
  logic               ready;
  logic [7:0]         rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_ev_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [7:0]         payload_byte;
  logic               reply_seq;
  logic [10:0]        payload_length;

  modport source (output valid, output event_kind, output payload_byte,
                  output reply_seq, output payload_length, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input reply_seq, input payload_length, output ready);
endinterface

// ===== design/stuffed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receiver: byte-stuffed information frame receiver
// Parses flag, address, control and header check, destuffs the data field,
// passes payload bytes one byte late and reports the frame outcome.
// ----------------------------------------------------------------------------
// An event is registered from its line byte and shows on the output in the
// cycle after that byte is accepted. One line byte per cycle unless the full
// output register stalls; the parse state updates in one pass. A single output
// register separates the sides; input is taken whenever it is empty or drained.
// Reset (async, active low) returns to waiting for an opening flag, clears
// sequence state and loads the default byte values into all config registers.
module stuffed_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sfr_rx_if.sink                      rx_if,
  sfr_ev_if.source                    ev_if,
  input  logic                        cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfr_pkg::ByteW-1:0]   cfg_data_i
);

  // configuration
  sfr_pkg::byte_t flag_q, esc_q, stuff_flag_q, esc_esc_q, addr_q, ctrl0_q, ctrl1_q;

  // parse state
  sfr_pkg::phase_e             phase_q, phase_d;
  logic                        esc_pend_q, esc_pend_d;
  logic                        frame_seq_q, frame_seq_d;
  logic                        exp_seq_q, exp_seq_d;
  sfr_pkg::byte_t              held_q, held_d;
  logic [sfr_pkg::CountW-1:0]  count_q, count_d;
  sfr_pkg::byte_t              xor_q, xor_d;

  // output register
  logic                        out_valid_q;
  sfr_pkg::event_e             kind_q;
  sfr_pkg::byte_t              obyte_q;
  logic                        oseq_q;
  logic [sfr_pkg::LenW-1:0]    olen_q;

  // result of this byte
  logic                        res_valid;
  sfr_pkg::event_e             res_kind;
  sfr_pkg::byte_t              res_byte;
  logic                        res_seq;
  logic [sfr_pkg::LenW-1:0]    res_len;

  logic                        accept;
  sfr_pkg::byte_t              b;
  logic                        is_flag, is_esc, is_ctrl0, is_ctrl1, seq_b;
  logic                        hchk_ok, bad_esc, closing, esc_start, room;
  sfr_pkg::byte_t              dest_byte;

  assign rx_if.ready = !out_valid_q || ev_if.ready;
  assign accept      = rx_if.valid && rx_if.ready;
  assign b           = rx_if.rx_byte;

  assign is_flag   = (b == flag_q);
  assign is_esc    = (b == esc_q);
  assign is_ctrl0  = (b == ctrl0_q);
  assign is_ctrl1  = (b == ctrl1_q);
  assign seq_b     = !is_ctrl0;   // both equal counts as sequence zero
  assign hchk_ok   = (b == (addr_q ^ (frame_seq_q ? ctrl1_q : ctrl0_q)));
  assign closing   = !esc_pend_q && is_flag;
  assign esc_start = !esc_pend_q && is_esc;
  assign bad_esc   = esc_pend_q && (b != stuff_flag_q) && (b != esc_esc_q);
  assign room      = (count_q < sfr_pkg::CountLimit);

  always_comb begin
    if (!esc_pend_q) begin
      dest_byte = b;
    end else if (b == stuff_flag_q) begin
      dest_byte = flag_q;
    end else begin
      dest_byte = esc_q;
    end
  end

  // next state
  always_comb begin
    phase_d     = phase_q;
    esc_pend_d  = esc_pend_q;
    frame_seq_d = frame_seq_q;
    exp_seq_d   = exp_seq_q;
    held_d      = held_q;
    count_d     = count_q;
    xor_d       = xor_q;
    if (accept) begin
      unique case (phase_q)
        sfr_pkg::PH_FLAG: begin
          if (is_flag) begin
            phase_d    = sfr_pkg::PH_ADDR;
            esc_pend_d = 1'b0;
            held_d     = '0;
            count_d    = '0;
            xor_d      = '0;
          end
        end
        sfr_pkg::PH_ADDR: begin
          phase_d = (b == addr_q) ? sfr_pkg::PH_CTRL : sfr_pkg::PH_FLAG;
        end
        sfr_pkg::PH_CTRL: begin
          phase_d = sfr_pkg::PH_FLAG;
          if ((is_ctrl0 || is_ctrl1) && (seq_b == exp_seq_q)) begin
            frame_seq_d = seq_b;
            phase_d     = sfr_pkg::PH_HCHK;
          end
        end
        sfr_pkg::PH_HCHK: begin
          phase_d = hchk_ok ? sfr_pkg::PH_DATA : sfr_pkg::PH_FLAG;
        end
        sfr_pkg::PH_DATA: begin
          if (closing) begin
            phase_d    = sfr_pkg::PH_FLAG;
            esc_pend_d = 1'b0;
            held_d     = '0;
            count_d    = '0;
            xor_d      = '0;
            if ((count_q != '0) && (xor_q == held_q)) begin
              exp_seq_d = !exp_seq_q;
            end
          end else if (esc_start) begin
            esc_pend_d = 1'b1;
          end else if (bad_esc || !room) begin
            phase_d    = sfr_pkg::PH_FLAG;
            esc_pend_d = 1'b0;
            held_d     = '0;
            count_d    = '0;
            xor_d      = '0;
          end else begin
            esc_pend_d = 1'b0;
            if (count_q != '0) begin
              xor_d = xor_q ^ held_q;
            end
            held_d  = dest_byte;
            count_d = count_q + 1'b1;
          end
        end
        default: begin
          phase_d    = sfr_pkg::PH_FLAG;
          esc_pend_d = 1'b0;
          held_d     = '0;
          count_d    = '0;
          xor_d      = '0;
        end
      endcase
    end
  end

  // event produced by this byte
  always_comb begin
    res_valid = 1'b0;
    res_kind  = sfr_pkg::EV_BYTE;
    res_byte  = '0;
    res_seq   = 1'b0;
    res_len   = '0;
    unique case (phase_q)
      sfr_pkg::PH_CTRL: begin
        if ((is_ctrl0 || is_ctrl1) && (seq_b != exp_seq_q)) begin
          res_valid = 1'b1;
          res_kind  = sfr_pkg::EV_DUP;
          res_seq   = exp_seq_q;
        end
      end
      sfr_pkg::PH_DATA: begin
        if (closing) begin
          res_valid = 1'b1;
          if (count_q == '0) begin
            res_kind = sfr_pkg::EV_ABORT;
          end else if (xor_q == held_q) begin
            res_kind = sfr_pkg::EV_GOOD;
            res_seq  = !frame_seq_q;
            res_len  = sfr_pkg::LenW'(count_q - 1'b1);
          end else begin
            res_kind = sfr_pkg::EV_CHECK;
            res_seq  = exp_seq_q;
          end
        end else if (esc_start) begin
          res_valid = 1'b0;
        end else if (bad_esc || !room) begin
          res_valid = 1'b1;
          res_kind  = sfr_pkg::EV_ABORT;
        end else if (count_q != '0) begin
          // pass the previous data byte on; the last one is the check byte
          res_valid = 1'b1;
          res_kind  = sfr_pkg::EV_BYTE;
          res_byte  = held_q;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q       <= sfr_pkg::FlagReset;
      esc_q        <= sfr_pkg::EscapeReset;
      stuff_flag_q <= sfr_pkg::EscFlagReset;
      esc_esc_q    <= sfr_pkg::EscEscReset;
      addr_q       <= sfr_pkg::AddressReset;
      ctrl0_q      <= sfr_pkg::CtrlS0Reset;
      ctrl1_q      <= sfr_pkg::CtrlS1Reset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfr_pkg::REG_FLAG:       flag_q       <= cfg_data_i;
        sfr_pkg::REG_ESCAPE:     esc_q        <= cfg_data_i;
        sfr_pkg::REG_STUFF_FLAG: stuff_flag_q <= cfg_data_i;
        sfr_pkg::REG_ESC_ESC:    esc_esc_q    <= cfg_data_i;
        sfr_pkg::REG_ADDRESS:    addr_q       <= cfg_data_i;
        sfr_pkg::REG_CTRL_SEQ0:  ctrl0_q      <= cfg_data_i;
        sfr_pkg::REG_CTRL_SEQ1:  ctrl1_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sfr_pkg::PH_FLAG;
      esc_pend_q  <= 1'b0;
      frame_seq_q <= 1'b0;
      exp_seq_q   <= 1'b0;
      held_q      <= '0;
      count_q     <= '0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      esc_pend_q  <= esc_pend_d;
      frame_seq_q <= frame_seq_d;
      exp_seq_q   <= exp_seq_d;
      held_q      <= held_d;
      count_q     <= count_d;
      xor_q       <= xor_d;
      if (accept) begin
        out_valid_q <= res_valid;
      end else if (ev_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // event payload, loaded only with a new event
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_q  <= res_kind;
      obyte_q <= res_byte;
      oseq_q  <= res_seq;
      olen_q  <= res_len;
    end
  end

  assign ev_if.valid          = out_valid_q;
  assign ev_if.event_kind     = kind_q;
  assign ev_if.payload_byte   = obyte_q;
  assign ev_if.reply_seq      = oseq_q;
  assign ev_if.payload_length = olen_q;

endmodule
